>>> hdl/prl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prl_pkg: shared types and constants for the point reflection block
// Coordinate widths, divider sizing and the item and line structs.
// ----------------------------------------------------------------------------
package prl_pkg;

  // coordinate and intermediate widths
  localparam int CW   = 32;          // coordinate
  localparam int DW   = CW + 1;      // difference of two coordinates
  localparam int PW   = 2 * DW;      // product of two differences
  localparam int DOTW = PW + 1;      // dot product
  localparam int QB   = 35;          // quotient magnitude bits
  localparam int RW   = PW;          // divider remainder, holds d.d
  localparam int NW   = QB + RW;     // numerator magnitude
  localparam int TW   = QB + 1;      // signed quotient
  localparam int SW   = 38;          // final sum before saturation
  localparam int LOW  = 34;          // low split of the dot product

  // register indexes of the configuration port
  localparam logic [1:0] REG_START_X = 2'd0;
  localparam logic [1:0] REG_START_Y = 2'd1;
  localparam logic [1:0] REG_END_X   = 2'd2;
  localparam logic [1:0] REG_END_Y   = 2'd3;

  // item as classified by the front part
  typedef struct packed {
    logic                 vert;
    logic signed [DW-1:0] qx;
    logic signed [DW-1:0] qy;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
  } item_t;

  // line values derived from the configuration registers
  typedef struct packed {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic        [RW-1:0] dd;
  } geom_t;

  // clamp to 32 bits: {clip, value}
  function automatic logic [CW:0] sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    hi = SW'(signed'({1'b0, {(CW-1){1'b1}}}));
    lo = SW'(signed'({1'b1, {(CW-1){1'b0}}}));
    if (v > hi) begin
      sat = {1'b1, hi[CW-1:0]};
    end else if (v < lo) begin
      sat = {1'b1, lo[CW-1:0]};
    end else begin
      sat = {1'b0, v[CW-1:0]};
    end
  endfunction

endpackage
`default_nettype wire

>>> hdl/prl_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prl_front: input stage
// Accepts points, forms the offset from the line start and flags a vertical line.
// ----------------------------------------------------------------------------
module prl_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic signed [prl_pkg::CW-1:0] point_x,
  input  wire logic signed [prl_pkg::CW-1:0] point_y,
  input  wire logic signed [prl_pkg::CW-1:0] start_x,
  input  wire logic signed [prl_pkg::CW-1:0] start_y,
  input  wire logic signed [prl_pkg::CW-1:0] end_x,
  input  wire logic                        q_full,
  output logic                             q_wr,
  output prl_pkg::item_t                   q_item
);
  import prl_pkg::*;

  logic  fv;
  item_t it;
  logic  take;

  // hand over to the queue whenever it has room
  assign q_wr   = fv & ~q_full;
  assign full   = fv & q_full;
  assign take   = push & ~full;
  assign q_item = it;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (take) begin
      fv <= 1'b1;
    end else if (q_wr) begin
      fv <= 1'b0;
    end
  end

  // classify and offset the point
  always_ff @(posedge clk) begin
    if (take) begin
      it.vert <= (start_x == end_x);
      it.qx   <= DW'(point_x) - DW'(start_x);
      it.qy   <= DW'(point_y) - DW'(start_y);
      it.px   <= point_x;
      it.py   <= point_y;
    end
  end

endmodule
`default_nettype wire

>>> hdl/prl_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prl_queue: two-entry item queue
// Decouples the front stage from the arithmetic pipeline.
// ----------------------------------------------------------------------------
module prl_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr,
  input  wire prl_pkg::item_t wdata,
  input  wire logic           rd,
  output prl_pkg::item_t      rdata,
  output logic                q_full,
  output logic                q_empty
);
  import prl_pkg::*;

  item_t      mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] cnt;

  assign q_full  = (cnt == 2'd2);
  assign q_empty = (cnt == 2'd0);
  assign rdata   = mem[rptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (wr) wptr <= ~wptr;
      if (rd) rptr <= ~rptr;
      cnt <= cnt + 2'(wr) - 2'(rd);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wdata;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(wr && q_full && !rd))
    else $error("write into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(rd && q_empty))
    else $error("read from empty queue");

endmodule
`default_nettype wire

>>> hdl/prl_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prl_back: reflection pipeline
// Dot product, numerator products, bit-per-stage divider, final sum and clamp.
// ----------------------------------------------------------------------------
module prl_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire prl_pkg::geom_t                geom,
  input  wire logic                          q_empty,
  output logic                               q_rd,
  input  wire prl_pkg::item_t                q_item,
  input  wire logic                          pop,
  output logic                               empty,
  output logic signed [prl_pkg::CW-1:0]      mirrored_x,
  output logic signed [prl_pkg::CW-1:0]      mirrored_y,
  output logic                               clipped
);
  import prl_pkg::*;

  typedef struct packed {
    logic                 vert;
    logic                 nx;
    logic                 ny;
    logic signed [DW-1:0] qx;
    logic signed [DW-1:0] qy;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
  } side_t;

  logic en;
  logic ov;

  // whole pipeline advances when the output slot frees up
  assign en    = ~ov | pop;
  assign q_rd  = en & ~q_empty;
  assign empty = ~ov;

  // stage 1: q.d products
  logic                 v1;
  item_t                i1;
  logic signed [PW-1:0] mxx, myy;
  // stage 2: dot product
  logic                   v2;
  item_t                  i2;
  logic signed [DOTW-1:0] dot;
  // stage 3: split products of dot by d
  logic                      v3;
  item_t                     i3;
  logic signed [PW+1:0]      plx, ply;
  logic signed [PW-1:0]      phx, phy;
  // stage 4: numerators
  logic                 v4;
  item_t                i4;
  logic signed [NW:0]   numx, numy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= q_rd;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i1   <= q_item;
      mxx  <= q_item.qx * geom.dx;
      myy  <= q_item.qy * geom.dy;
      i2   <= i1;
      dot  <= DOTW'(mxx) + DOTW'(myy);
      i3   <= i2;
      plx  <= $signed({1'b0, dot[LOW-1:0]}) * geom.dx;
      ply  <= $signed({1'b0, dot[LOW-1:0]}) * geom.dy;
      phx  <= $signed(dot[DOTW-1:LOW]) * geom.dx;
      phy  <= $signed(dot[DOTW-1:LOW]) * geom.dy;
      i4   <= i3;
      numx <= ((NW+1)'(phx) <<< (LOW + 1)) + ((NW+1)'(plx) <<< 1);
      numy <= ((NW+1)'(phy) <<< (LOW + 1)) + ((NW+1)'(ply) <<< 1);
    end
  end

  // divider: stage 0 holds magnitudes, each later stage settles one quotient bit
  logic              dv   [QB+1];
  side_t             sd   [QB+1];
  logic [RW-1:0]     remx [QB+1];
  logic [RW-1:0]     remy [QB+1];
  logic [QB-1:0]     nlx  [QB+1];
  logic [QB-1:0]     nly  [QB+1];
  logic [QB-1:0]     qtx  [QB+1];
  logic [QB-1:0]     qty  [QB+1];
  logic [NW-1:0]     magx, magy;

  assign magx = numx[NW] ? NW'(-numx) : NW'(numx);
  assign magy = numy[NW] ? NW'(-numy) : NW'(numy);

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0].vert <= i4.vert;
      sd[0].nx   <= numx[NW];
      sd[0].ny   <= numy[NW];
      sd[0].qx   <= i4.qx;
      sd[0].qy   <= i4.qy;
      sd[0].px   <= i4.px;
      sd[0].py   <= i4.py;
      remx[0]    <= magx[NW-1:QB];
      remy[0]    <= magy[NW-1:QB];
      nlx[0]     <= magx[QB-1:0];
      nly[0]     <= magy[QB-1:0];
      qtx[0]     <= '0;
      qty[0]     <= '0;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [RW:0] r2x, r2y;
    logic        gex, gey;
    assign r2x = {remx[k], nlx[k][QB-1]};
    assign r2y = {remy[k], nly[k][QB-1]};
    assign gex = r2x >= {1'b0, geom.dd};
    assign gey = r2y >= {1'b0, geom.dd};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (en) begin
        dv[k+1] <= dv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[k+1]   <= sd[k];
        remx[k+1] <= gex ? RW'(r2x - {1'b0, geom.dd}) : RW'(r2x);
        remy[k+1] <= gey ? RW'(r2y - {1'b0, geom.dd}) : RW'(r2y);
        nlx[k+1]  <= nlx[k] << 1;
        nly[k+1]  <= nly[k] << 1;
        qtx[k+1]  <= {qtx[k][QB-2:0], gex};
        qty[k+1]  <= {qty[k][QB-2:0], gey};
      end
    end
  end

  // signed quotients
  logic                 vf;
  side_t                sf;
  logic signed [TW-1:0] tx, ty;

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (en) begin
      vf <= dv[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sf <= sd[QB];
      tx <= sd[QB].nx ? -$signed({1'b0, qtx[QB]}) : $signed({1'b0, qtx[QB]});
      ty <= sd[QB].ny ? -$signed({1'b0, qty[QB]}) : $signed({1'b0, qty[QB]});
    end
  end

  // final sum and clamp into the output register
  logic signed [SW-1:0] rx, ry;
  logic [CW:0]          cx, cy;

  always_comb begin
    if (sf.vert) begin
      rx = (SW'(geom.sx) <<< 1) - SW'(sf.px);
      ry = SW'(sf.py);
    end else begin
      rx = SW'(geom.sx) + SW'(tx) - SW'(sf.qx);
      ry = SW'(geom.sy) + SW'(ty) - SW'(sf.qy);
    end
    cx = sat(rx);
    cy = sat(ry);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (en) begin
      ov <= vf;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mirrored_x <= $signed(cx[CW-1:0]);
      mirrored_y <= $signed(cy[CW-1:0]);
      clipped    <= cx[CW] | cy[CW];
    end
  end

endmodule
`default_nettype wire

>>> hdl/point_reflection_across_line.sv
`default_nettype none
// ----------------------------------------------------------------------------
// point_reflection_across_line: mirror points across a configured line
// Top level: configuration registers, front stage, queue and pipeline.
// ----------------------------------------------------------------------------
// Each point (signed Q16.16) is reflected across the line through the two
// configured points and clamped to 32 bits, with clipped set on a clamp. One
// point is accepted per clock and one result leaves per clock while results
// are popped; the divider settles one of 35 quotient bits per pipeline stage.
// The pipeline stalls as a whole only while the result at the head is not
// popped; the front register and a two-entry queue take up to three more
// points meanwhile before full rises. Write the line registers only while no
// point is in flight.
module point_reflection_across_line (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [prl_pkg::CW-1:0]        cfg_data,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic signed [prl_pkg::CW-1:0] point_x,
  input  wire logic signed [prl_pkg::CW-1:0] point_y,
  input  wire logic                          pop,
  output logic                               empty,
  output logic signed [prl_pkg::CW-1:0]      mirrored_x,
  output logic signed [prl_pkg::CW-1:0]      mirrored_y,
  output logic                               clipped
);
  import prl_pkg::*;

  logic signed [CW-1:0] sx, sy, ex, ey;
  logic signed [DW-1:0] dx, dy;
  logic        [PW-1:0] dx2, dy2;
  logic        [RW-1:0] dd;
  geom_t                geom;

  // line registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sx <= '0;
      sy <= '0;
      ex <= '0;
      ey <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_X: sx <= $signed(cfg_data);
        REG_START_Y: sy <= $signed(cfg_data);
        REG_END_X:   ex <= $signed(cfg_data);
        REG_END_Y:   ey <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // line direction and squared length, refreshed every cycle
  always_ff @(posedge clk) begin
    dx  <= DW'(ex) - DW'(sx);
    dy  <= DW'(ey) - DW'(sy);
    dx2 <= PW'(dx * dx);
    dy2 <= PW'(dy * dy);
    dd  <= dx2 + dy2;
  end

  assign geom = '{sx: sx, sy: sy, dx: dx, dy: dy, dd: dd};

  logic  q_full, q_empty, q_wr, q_rd;
  item_t q_in, q_out;

  prl_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .point_x (point_x),
    .point_y (point_y),
    .start_x (sx),
    .start_y (sy),
    .end_x   (ex),
    .q_full  (q_full),
    .q_wr    (q_wr),
    .q_item  (q_in)
  );

  prl_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wdata   (q_in),
    .rd      (q_rd),
    .rdata   (q_out),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  prl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .geom       (geom),
    .q_empty    (q_empty),
    .q_rd       (q_rd),
    .q_item     (q_out),
    .pop        (pop),
    .empty      (empty),
    .mirrored_x (mirrored_x),
    .mirrored_y (mirrored_y),
    .clipped    (clipped)
  );

endmodule
`default_nettype wire
